// ===== rtl/core/pbfm_pkg.sv =====
// ----------------------------------------------------------------------------
// pbfm_pkg: shared constants for the page buffer frame manager
// Request codes, field widths and parameter defaults.
// ----------------------------------------------------------------------------
`default_nettype none
package pbfm_pkg;
    localparam int NUM_FRAMES_DEF = 16;
    localparam int PIN_BITS_DEF   = 8;
    localparam int PID_W          = 31;
    localparam int CMD_W          = 3;
    localparam int FRAME_W        = 6;
    localparam int IN_TDATA_W     = 64;
    localparam int OUT_TDATA_W    = 80;

    localparam logic [CMD_W-1:0] CMD_FETCH = 3'd0;
    localparam logic [CMD_W-1:0] CMD_UNPIN = 3'd1;
    localparam logic [CMD_W-1:0] CMD_FLUSH = 3'd2;
    localparam logic [CMD_W-1:0] CMD_NEW   = 3'd3;
    localparam logic [CMD_W-1:0] CMD_DEL   = 3'd4;
    localparam logic [CMD_W-1:0] CMD_FALL  = 3'd5;
endpackage
`default_nettype wire

// ===== rtl/core/pbfm_ram.sv =====
// ----------------------------------------------------------------------------
// pbfm_ram: single-port synchronous RAM
// One access per cycle, read data registered and held while not enabled.
// ----------------------------------------------------------------------------
`default_nettype none
module pbfm_ram
    import pbfm_pkg::*;
#(
    parameter int WIDTH = PID_W,
    parameter int DEPTH = NUM_FRAMES_DEF,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic             i_re,
    input  wire logic [AW-1:0]    i_addr,
    input  wire logic [WIDTH-1:0] i_wdata,
    output logic      [WIDTH-1:0] o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_addr];
        end
    end
endmodule
`default_nettype wire

// ===== rtl/core/page_buffer_frame_manager_top.sv =====
// ----------------------------------------------------------------------------
// page_buffer_frame_manager_top: page cache frame manager
// Maps page ids to frames, tracks pins and dirty marks, picks free frames in
// FIFO order and then least recently unpinned victims.
//
//   channel  dir  tdata                                   side bits
//   s        in   page_id, dirty, new_page_id            tuser = cmd
//   m        out  ok, frame, result_page_id, writeback,   tlast = last
//                 writeback_page_id, read_in, zero_fill,
//                 deallocate
//
// A lookup request scans the page-id RAM one frame a cycle and then decides
// its result; a miss that takes a frame also reads the victim's old page id
// before its result. Flush all reads and then emits each frame in turn. One
// request is in work at a time; the next is taken once the block is idle.
// Synchronous active-low reset; no clearing pass. Output stalls hold the
// block in its current step.
// ----------------------------------------------------------------------------
`default_nettype none
module page_buffer_frame_manager_top
    import pbfm_pkg::*;
#(
    parameter int NUM_FRAMES = NUM_FRAMES_DEF,
    parameter int PIN_BITS   = PIN_BITS_DEF
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_s_tvalid,
    output logic                        o_s_tready,
    // [30:0] page_id, [31] dirty, [62:32] new_page_id
    input  wire logic [IN_TDATA_W-1:0]  i_s_tdata,
    // [2:0] cmd
    input  wire logic [CMD_W-1:0]       i_s_tuser,
    output logic                        o_m_tvalid,
    input  wire logic                   i_m_tready,
    // [0] ok, [6:1] frame, [37:7] result_page_id, [38] writeback,
    // [69:39] writeback_page_id, [70] read_in, [71] zero_fill, [72] deallocate
    output logic [OUT_TDATA_W-1:0]      o_m_tdata,
    output logic                        o_m_tlast
);
    localparam int FW = (NUM_FRAMES > 1) ? $clog2(NUM_FRAMES) : 1;
    localparam int CW = $clog2(NUM_FRAMES + 1);
    localparam logic [PIN_BITS-1:0] PIN_MAX = {PIN_BITS{1'b1}};
    localparam logic [FW-1:0] LAST_F = FW'(NUM_FRAMES - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(NUM_FRAMES);

    typedef logic [NUM_FRAMES-1:0][FW-1:0] t_list;
    typedef enum logic [2:0] {
        ST_IDLE, ST_SCAN, ST_SCAN_END, ST_EXEC, ST_VICT, ST_FA_RD, ST_FA_WR
    } t_state;

    t_state                 r_state;
    logic [CMD_W-1:0]       r_cmd;
    logic [PID_W-1:0]       r_pid, r_npid;
    logic                   r_dty;
    logic [FW-1:0]          r_idx, r_rd_idx, r_hf, r_vf;
    logic                   r_rd_vld, r_hit;
    logic [NUM_FRAMES-1:0]  r_valid, r_dirty;
    logic [NUM_FRAMES-1:0][PIN_BITS-1:0] r_pin;
    t_list                  r_free, r_lru;
    logic [CW-1:0]          r_fcnt, r_lcnt;

    logic                   r_ov, r_ok, r_wb, r_rd, r_zf, r_dl, r_last;
    logic [FW-1:0]          r_frame;
    logic [PID_W-1:0]       r_rpid, r_wbpid;

    logic                   ram_we, ram_re;
    logic [FW-1:0]          ram_addr;
    logic [PID_W-1:0]       ram_rdata, target;
    logic                   can_emit, scan_match, need_frame, emit;

    logic                   n_ok, n_wb, n_zf, n_dl;
    logic [FW-1:0]          n_frame;
    logic [PID_W-1:0]       n_rpid, n_wbpid;

    pbfm_ram #(.WIDTH(PID_W), .DEPTH(NUM_FRAMES)) u_page_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_re    (ram_re),
        .i_addr  (ram_addr),
        .i_wdata (target),
        .o_rdata (ram_rdata)
    );

    // Drop one entry and close the gap; removal of position 0 is a pop.
    function automatic t_list list_drop(t_list a, logic [CW-1:0] cnt,
                                        logic [FW-1:0] f, logic head);
        t_list res;
        logic  seen;
        seen = 1'b0;
        for (int i = 0; i < NUM_FRAMES; i++) begin
            seen = seen | head | ((CW'(i) < cnt) && (a[i] == f));
            if (seen && i < NUM_FRAMES - 1) res[i] = a[i+1];
            else                            res[i] = a[i];
        end
        return res;
    endfunction

    function automatic logic list_has(t_list a, logic [CW-1:0] cnt,
                                      logic [FW-1:0] f);
        logic hit;
        hit = 1'b0;
        for (int i = 0; i < NUM_FRAMES; i++) begin
            hit = hit | ((CW'(i) < cnt) && (a[i] == f));
        end
        return hit;
    endfunction

    assign target     = (r_cmd == CMD_NEW) ? r_npid : r_pid;
    assign can_emit   = !r_ov || i_m_tready;
    assign scan_match = r_rd_vld && r_valid[r_rd_idx] && (ram_rdata == target);
    assign o_s_tready = (r_state == ST_IDLE);
    assign need_frame = (r_cmd == CMD_FETCH || r_cmd == CMD_NEW) && !r_hit
                        && (r_fcnt != '0 || r_lcnt != '0);
    assign emit       = can_emit && (((r_state == ST_EXEC) && !need_frame)
                                     || r_state == ST_VICT || r_state == ST_FA_WR);

    always_comb begin
        ram_we   = 1'b0;
        ram_re   = 1'b0;
        ram_addr = r_idx;
        unique case (r_state)
            ST_SCAN:  ram_re = 1'b1;
            ST_FA_RD: ram_re = 1'b1;
            ST_EXEC: begin
                ram_addr = (r_fcnt != '0) ? r_free[0] : r_lru[0];
                ram_re   = need_frame;
            end
            ST_VICT: begin
                ram_addr = r_vf;
                ram_we   = can_emit;
            end
            default: ;
        endcase
    end

    // result item of a request that needs no new frame; failure is all zero
    always_comb begin
        n_ok    = 1'b0;
        n_frame = '0;
        n_rpid  = '0;
        n_wb    = 1'b0;
        n_wbpid = '0;
        n_zf    = 1'b0;
        n_dl    = 1'b0;
        case (r_cmd)
            CMD_FETCH: begin
                if (r_hit && r_pin[r_hf] != PIN_MAX) begin
                    n_ok = 1'b1; n_frame = r_hf; n_rpid = r_pid;
                end
            end
            CMD_UNPIN: begin
                if (r_hit && r_pin[r_hf] != '0) begin
                    n_ok = 1'b1; n_frame = r_hf; n_rpid = r_pid;
                end
            end
            CMD_FLUSH: begin
                if (r_hit) begin
                    n_ok = 1'b1; n_frame = r_hf; n_rpid = r_pid;
                    n_wb = r_dirty[r_hf];
                    n_wbpid = r_dirty[r_hf] ? r_pid : '0;
                end
            end
            CMD_DEL: begin
                if (!r_hit) begin
                    n_ok = 1'b1; n_rpid = r_pid;
                end else if (r_pin[r_hf] == '0) begin
                    n_ok = 1'b1; n_frame = r_hf; n_rpid = r_pid;
                    n_zf = 1'b1; n_dl = 1'b1;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_rd_vld <= 1'b0;
            r_hit    <= 1'b0;
            r_valid  <= '0;
            r_dirty  <= '0;
            r_pin    <= '0;
            r_lcnt   <= '0;
            r_fcnt   <= FULL_CNT;
            r_ov     <= 1'b0;
            for (int i = 0; i < NUM_FRAMES; i++) begin
                r_free[i] <= FW'(i);
            end
        end else begin
            if (i_m_tready && !emit) begin
                r_ov <= 1'b0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    r_rd_vld <= 1'b0;
                    r_hit    <= 1'b0;
                    r_idx    <= '0;
                    if (i_s_tvalid) begin
                        r_cmd  <= i_s_tuser;
                        r_pid  <= i_s_tdata[PID_W-1:0];
                        r_dty  <= i_s_tdata[PID_W];
                        r_npid <= i_s_tdata[2*PID_W:PID_W+1];
                        if (i_s_tuser == CMD_FALL)                         r_state <= ST_FA_RD;
                        else if (i_s_tuser > CMD_FALL)                     r_state <= ST_EXEC;
                        else                                               r_state <= ST_SCAN;
                    end
                end
                ST_SCAN, ST_SCAN_END: begin
                    if (scan_match) begin
                        r_hit <= 1'b1;
                        r_hf  <= r_rd_idx;
                    end
                    r_rd_vld <= (r_state == ST_SCAN);
                    r_rd_idx <= r_idx;
                    if (r_state == ST_SCAN_END)  r_state <= ST_EXEC;
                    else if (r_idx == LAST_F)    r_state <= ST_SCAN_END;
                    else                         r_idx <= r_idx + 1'b1;
                end
                ST_EXEC: begin
                    if (need_frame) begin
                        // take a frame now, emit after the old page id is read
                        if (r_fcnt != '0) begin
                            r_vf   <= r_free[0];
                            r_free <= list_drop(r_free, r_fcnt, '0, 1'b1);
                            r_fcnt <= r_fcnt - 1'b1;
                        end else begin
                            r_vf   <= r_lru[0];
                            r_lru  <= list_drop(r_lru, r_lcnt, '0, 1'b1);
                            r_lcnt <= r_lcnt - 1'b1;
                        end
                        r_state <= ST_VICT;
                    end else if (can_emit) begin
                        r_ov    <= 1'b1;
                        r_ok    <= n_ok;
                        r_frame <= n_frame;
                        r_rpid  <= n_rpid;
                        r_wb    <= n_wb;
                        r_wbpid <= n_wbpid;
                        r_rd    <= 1'b0;
                        r_zf    <= n_zf;
                        r_dl    <= n_dl;
                        r_last  <= 1'b1;
                        r_state <= ST_IDLE;
                        case (r_cmd)
                            CMD_FETCH: begin
                                if (r_hit && r_pin[r_hf] != PIN_MAX) begin
                                    r_pin[r_hf] <= r_pin[r_hf] + 1'b1;
                                    if (list_has(r_lru, r_lcnt, r_hf)) begin
                                        r_lru  <= list_drop(r_lru, r_lcnt, r_hf, 1'b0);
                                        r_lcnt <= r_lcnt - 1'b1;
                                    end
                                end
                            end
                            CMD_UNPIN: begin
                                if (r_hit && r_pin[r_hf] != '0) begin
                                    r_dirty[r_hf] <= r_dirty[r_hf] | r_dty;
                                    r_pin[r_hf]   <= r_pin[r_hf] - 1'b1;
                                    if (r_pin[r_hf] == PIN_BITS'(1) && r_lcnt != FULL_CNT
                                        && !list_has(r_lru, r_lcnt, r_hf)) begin
                                        r_lru[r_lcnt[FW-1:0]] <= r_hf;
                                        r_lcnt <= r_lcnt + 1'b1;
                                    end
                                end
                            end
                            CMD_FLUSH: begin
                                if (r_hit) begin
                                    r_dirty[r_hf] <= 1'b0;
                                end
                            end
                            CMD_DEL: begin
                                if (r_hit && r_pin[r_hf] == '0) begin
                                    r_valid[r_hf] <= 1'b0;
                                    r_dirty[r_hf] <= 1'b0;
                                    if (list_has(r_lru, r_lcnt, r_hf)) begin
                                        r_lru  <= list_drop(r_lru, r_lcnt, r_hf, 1'b0);
                                        r_lcnt <= r_lcnt - 1'b1;
                                    end
                                    if (r_fcnt != FULL_CNT) begin
                                        r_free[r_fcnt[FW-1:0]] <= r_hf;
                                        r_fcnt <= r_fcnt + 1'b1;
                                    end
                                end
                            end
                            default: ;
                        endcase
                    end
                end
                ST_VICT: begin
                    if (can_emit) begin
                        r_ov    <= 1'b1;
                        r_ok    <= 1'b1;
                        r_frame <= r_vf;
                        r_rpid  <= target;
                        r_wb    <= r_valid[r_vf] && r_dirty[r_vf];
                        r_wbpid <= (r_valid[r_vf] && r_dirty[r_vf]) ? ram_rdata : '0;
                        r_rd    <= (r_cmd == CMD_FETCH);
                        r_zf    <= (r_cmd == CMD_NEW);
                        r_dl    <= 1'b0;
                        r_last  <= 1'b1;
                        r_valid[r_vf] <= 1'b1;
                        r_dirty[r_vf] <= 1'b0;
                        r_pin[r_vf]   <= PIN_BITS'(1);
                        r_state <= ST_IDLE;
                    end
                end
                ST_FA_RD: r_state <= ST_FA_WR;
                ST_FA_WR: begin
                    if (can_emit) begin
                        r_ov    <= 1'b1;
                        r_ok    <= r_valid[r_idx];
                        r_frame <= r_idx;
                        r_rpid  <= r_valid[r_idx] ? ram_rdata : '0;
                        r_wb    <= r_valid[r_idx] && r_dirty[r_idx];
                        r_wbpid <= (r_valid[r_idx] && r_dirty[r_idx]) ? ram_rdata : '0;
                        r_rd    <= 1'b0;
                        r_zf    <= 1'b0;
                        r_dl    <= 1'b0;
                        r_last  <= (r_idx == LAST_F);
                        if (r_valid[r_idx]) begin
                            r_dirty[r_idx] <= 1'b0;
                        end
                        if (r_idx == LAST_F) begin
                            r_state <= ST_IDLE;
                        end else begin
                            r_idx   <= r_idx + 1'b1;
                            r_state <= ST_FA_RD;
                        end
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign o_m_tvalid = r_ov;
    assign o_m_tlast  = r_last;
    assign o_m_tdata  = {7'd0, r_dl, r_zf, r_rd, r_wbpid, r_wb, r_rpid,
                         FRAME_W'(r_frame), r_ok};

`ifndef SYNTHESIS
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready) |=> !o_s_tready)
        else $error("request accepted while another is in work");
    a_lists_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (32'(r_fcnt) + 32'(r_lcnt)) <= NUM_FRAMES)
        else $error("free and LRU lists hold more frames than the pool");
    a_victim_unpinned: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_VICT) |-> (r_pin[r_vf] == '0))
        else $error("pinned frame taken as victim");
`endif
endmodule
`default_nettype wire

// ===== verif/tb_page_buffer_frame_manager_top.sv =====
// ----------------------------------------------------------------------------
// tb_page_buffer_frame_manager_top: self-checking bench for the frame manager
// Drives requests on the input stream, predicts every result with its own
// model of the page map, pin counts, dirty marks, free FIFO and LRU list,
// and compares each result item field by field in arrival order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_page_buffer_frame_manager_top;
    import pbfm_pkg::*;

    localparam int FRAMES = NUM_FRAMES_DEF;
    localparam int PIN_LIMIT = (1 << PIN_BITS_DEF) - 1;
    localparam logic [CMD_W-1:0] CMD_RSVD6 = 3'd6;
    localparam logic [CMD_W-1:0] CMD_RSVD7 = 3'd7;
    localparam int ID_POOL = 24;

    typedef struct packed {
        logic               ok;
        logic [FRAME_W-1:0] frame;
        logic [PID_W-1:0]   page;
        logic               wb;
        logic [PID_W-1:0]   wb_page;
        logic               rd;
        logic               zf;
        logic               dealloc;
        logic               last;
    } t_frame_result;

    class frame_map_scoreboard;
        logic [PID_W-1:0] page_of[FRAMES];
        bit               mapped[FRAMES];
        int               pins[FRAMES];
        bit               dirty[FRAMES];
        int               free_fifo[$];
        int               lru_list[$];
        t_frame_result    expected_results[$];
        int               errors;

        function new();
            for (int i = 0; i < FRAMES; i++) begin
                page_of[i] = '0;
                mapped[i] = 0;
                pins[i] = 0;
                dirty[i] = 0;
                free_fifo.push_back(i);
            end
            errors = 0;
        endfunction

        function int find_frame(logic [PID_W-1:0] p);
            for (int i = 0; i < FRAMES; i++)
                if (mapped[i] && page_of[i] == p) return i;
            return -1;
        endfunction

        function void lru_drop(int f);
            for (int i = lru_list.size() - 1; i >= 0; i--)
                if (lru_list[i] == f) lru_list.delete(i);
        endfunction

        function void push_result(bit ok, int frame, logic [PID_W-1:0] page, bit wb,
                                  logic [PID_W-1:0] wb_page, bit rd, bit zf,
                                  bit dealloc, bit last);
            t_frame_result r;
            r.ok = ok;
            r.frame = frame[FRAME_W-1:0];
            r.page = page;
            r.wb = wb;
            r.wb_page = wb ? wb_page : '0;
            r.rd = rd;
            r.zf = zf;
            r.dealloc = dealloc;
            r.last = last;
            expected_results.push_back(r);
        endfunction

        function void refuse();
            push_result(0, 0, '0, 0, '0, 0, 0, 0, 1);
        endfunction

        function void note_request(logic [CMD_W-1:0] cmd, logic [PID_W-1:0] pid,
                                   bit dty, logic [PID_W-1:0] npid);
            int f;
            logic [PID_W-1:0] target;
            bit wb;
            logic [PID_W-1:0] old_page;
            case (cmd)
                CMD_FETCH, CMD_NEW: begin
                    target = (cmd == CMD_FETCH) ? pid : npid;
                    f = find_frame(target);
                    if (f >= 0) begin
                        if (cmd == CMD_NEW || pins[f] >= PIN_LIMIT) begin
                            refuse();
                        end else begin
                            pins[f]++;
                            lru_drop(f);
                            push_result(1, f, target, 0, '0, 0, 0, 0, 1);
                        end
                    end else if (free_fifo.size() == 0 && lru_list.size() == 0) begin
                        refuse();
                    end else begin
                        if (free_fifo.size() > 0) begin
                            f = free_fifo[0];
                            free_fifo.delete(0);
                        end else begin
                            f = lru_list[0];
                            lru_list.delete(0);
                        end
                        wb = mapped[f] && dirty[f];
                        old_page = page_of[f];
                        page_of[f] = target;
                        mapped[f] = 1;
                        pins[f] = 1;
                        dirty[f] = 0;
                        push_result(1, f, target, wb, old_page, cmd == CMD_FETCH,
                                    cmd == CMD_NEW, 0, 1);
                    end
                end
                CMD_UNPIN: begin
                    f = find_frame(pid);
                    if (f < 0 || pins[f] == 0) begin
                        refuse();
                    end else begin
                        dirty[f] |= dty;
                        pins[f]--;
                        if (pins[f] == 0) begin
                            lru_drop(f);
                            lru_list.push_back(f);
                        end
                        push_result(1, f, pid, 0, '0, 0, 0, 0, 1);
                    end
                end
                CMD_FLUSH: begin
                    f = find_frame(pid);
                    if (f < 0) begin
                        refuse();
                    end else begin
                        push_result(1, f, pid, dirty[f], pid, 0, 0, 0, 1);
                        dirty[f] = 0;
                    end
                end
                CMD_DEL: begin
                    f = find_frame(pid);
                    if (f < 0) begin
                        push_result(1, 0, pid, 0, '0, 0, 0, 0, 1);
                    end else if (pins[f] != 0) begin
                        refuse();
                    end else begin
                        mapped[f] = 0;
                        page_of[f] = '0;
                        dirty[f] = 0;
                        lru_drop(f);
                        free_fifo.push_back(f);
                        push_result(1, f, pid, 0, '0, 0, 1, 1, 1);
                    end
                end
                CMD_FALL: begin
                    for (int i = 0; i < FRAMES; i++) begin
                        if (mapped[i]) begin
                            push_result(1, i, page_of[i], dirty[i], page_of[i], 0, 0, 0,
                                        i == FRAMES - 1);
                            dirty[i] = 0;
                        end else begin
                            push_result(0, i, '0, 0, '0, 0, 0, 0, i == FRAMES - 1);
                        end
                    end
                end
                default: refuse();
            endcase
        endfunction

        function void check_result(logic [OUT_TDATA_W-1:0] data, logic last);
            t_frame_result got, want;
            got.ok = data[0];
            got.frame = data[6:1];
            got.page = data[37:7];
            got.wb = data[38];
            got.wb_page = data[69:39];
            got.rd = data[70];
            got.zf = data[71];
            got.dealloc = data[72];
            got.last = last;
            if (expected_results.size() == 0) begin
                errors++;
                if (errors <= 10) $display("unexpected result item: %p", got);
                return;
            end
            want = expected_results[0];
            expected_results.delete(0);
            if (got.ok !== want.ok || got.frame !== want.frame || got.page !== want.page
                || got.wb !== want.wb || got.wb_page !== want.wb_page
                || got.rd !== want.rd || got.zf !== want.zf
                || got.dealloc !== want.dealloc || got.last !== want.last) begin
                errors++;
                if (errors <= 10) begin
                    $display("result mismatch at %0t", $realtime);
                    $display("  expected %p", want);
                    $display("  actual   %p", got);
                end
            end
        endfunction
    endclass

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   i_s_tvalid;
    logic                   o_s_tready;
    logic [IN_TDATA_W-1:0]  i_s_tdata;
    logic [CMD_W-1:0]       i_s_tuser;
    logic                   o_m_tvalid;
    logic                   i_m_tready;
    logic [OUT_TDATA_W-1:0] o_m_tdata;
    logic                   o_m_tlast;

    page_buffer_frame_manager_top i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tlast  (o_m_tlast)
    );

    frame_map_scoreboard frame_map = new();
    int src_idle_pct;
    int sink_idle_pct;
    int sink_hold_cycles;
    logic [PID_W-1:0] ids[ID_POOL];

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #20ms;
        $display("page_buffer_frame_manager_top: mismatch");
        $finish;
    end

    // Result side: check accepted items, then pick next ready.
    initial begin
        i_m_tready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_m_tvalid && i_m_tready)
                frame_map.check_result(o_m_tdata, o_m_tlast);
            if (sink_hold_cycles > 0) begin
                sink_hold_cycles--;
                i_m_tready <= 1'b0;
            end else begin
                i_m_tready <= ($urandom_range(99) >= sink_idle_pct);
            end
        end
    end

    task automatic send_request(logic [CMD_W-1:0] cmd, logic [PID_W-1:0] pid, bit dty,
                                logic [PID_W-1:0] npid);
        if ($urandom_range(99) < src_idle_pct) begin
            i_s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tuser <= cmd;
        i_s_tdata <= {1'b0, npid, dty, pid};
        do @(posedge i_clk); while (!o_s_tready);
        frame_map.note_request(cmd, pid, dty, npid);
    endtask

    task automatic drain();
        i_s_tvalid <= 1'b0;
        while (frame_map.expected_results.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    function automatic logic [PID_W-1:0] any_id();
        return ($urandom_range(9) == 0) ? PID_W'($urandom) : ids[$urandom_range(ID_POOL - 1)];
    endfunction

    task automatic random_request();
        int pick;
        logic [CMD_W-1:0] cmd;
        pick = $urandom_range(99);
        if (pick < 30) cmd = CMD_FETCH;
        else if (pick < 60) cmd = CMD_UNPIN;
        else if (pick < 70) cmd = CMD_FLUSH;
        else if (pick < 80) cmd = CMD_NEW;
        else if (pick < 93) cmd = CMD_DEL;
        else if (pick < 97) cmd = CMD_FALL;
        else cmd = $urandom_range(1) ? CMD_RSVD6 : CMD_RSVD7;
        send_request(cmd, any_id(), 1'($urandom_range(1)), any_id());
    endtask

    task automatic random_phase(int count);
        for (int n = 0; n < count; n++) begin
            // occasionally exhaust every frame with pinned pages, then release them
            if ($urandom_range(99) == 0) begin
                for (int k = 0; k < FRAMES + 2; k++)
                    send_request(CMD_FETCH, ids[k], 0, '0);
                send_request(CMD_NEW, '0, 0, PID_W'($urandom));
                for (int k = 0; k < FRAMES + 2; k++)
                    send_request(CMD_UNPIN, ids[k], 1'($urandom_range(1)), '0);
            end else begin
                random_request();
            end
        end
    endtask

    initial begin
        i_rst_n <= 1'b0;
        i_s_tvalid <= 1'b0;
        i_s_tdata <= '0;
        i_s_tuser <= CMD_FETCH;
        src_idle_pct = 16;
        sink_idle_pct = 84;
        sink_hold_cycles = 0;
        ids[0] = '0;
        ids[1] = '1;
        for (int i = 2; i < ID_POOL; i++)
            ids[i] = (i < 8) ? PID_W'(i) : PID_W'($urandom);
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_request(CMD_FETCH, ids[0], 0, ids[1]);
        send_request(CMD_FETCH, ids[1], 1, '0);
        send_request(CMD_UNPIN, ids[0], 1, '0);
        send_request(CMD_FLUSH, ids[0], 0, '0);
        send_request(CMD_FLUSH, ids[0], 0, '0);
        send_request(CMD_UNPIN, ids[1], 0, '0);
        send_request(CMD_UNPIN, ids[1], 1, '0);
        send_request(CMD_UNPIN, ids[5], 0, '0);
        send_request(CMD_FLUSH, ids[5], 1, '0);
        send_request(CMD_NEW, '1, 1, ids[5]);
        send_request(CMD_NEW, '0, 0, ids[5]);
        send_request(CMD_DEL, ids[5], 0, '0);
        send_request(CMD_UNPIN, ids[5], 1, '0);
        send_request(CMD_DEL, ids[5], 0, '0);
        send_request(CMD_DEL, ids[5], 0, '0);
        send_request(CMD_FETCH, ids[0], 0, '0);
        send_request(CMD_UNPIN, ids[0], 1, '0);
        send_request(CMD_FALL, '1, 1, '1);
        send_request(CMD_FALL, '0, 0, '0);
        send_request(CMD_RSVD6, ids[0], 1, '1);
        send_request(CMD_RSVD7, '1, 0, '0);

        random_phase(40);
        drain();

        src_idle_pct = 84;
        sink_idle_pct = 16;
        random_phase(40);
        // hold the sender until the pool is quiet
        drain();

        src_idle_pct = 0;
        sink_idle_pct = 0;
        sink_hold_cycles = 400;
        random_phase(10);
        // walk one page up to its pin ceiling and partly back down
        for (int k = 0; k < PIN_LIMIT + 2; k++)
            send_request(CMD_FETCH, ids[3], 0, '0);
        for (int k = 0; k < 16; k++)
            send_request(CMD_UNPIN, ids[3], 1'($urandom_range(1)), '0);
        random_phase(30);
        drain();

        if (frame_map.errors == 0 && frame_map.expected_results.size() == 0)
            $display("page_buffer_frame_manager_top: match");
        else
            $display("page_buffer_frame_manager_top: mismatch");
        $finish;
    end
endmodule

// ===== sim.f =====
rtl/core/pbfm_pkg.sv
rtl/core/pbfm_ram.sv
rtl/core/page_buffer_frame_manager_top.sv
verif/tb_page_buffer_frame_manager_top.sv
